// ----- hdl/cptc_pkg.sv -----
// shared constants and register index codes for the pendulum torque controller
`default_nettype none
package cptc_pkg;

  localparam int unsigned NUM_CFG = 7;

  typedef enum logic [2:0] {
    CFG_RADIUS    = 3'd0,
    CFG_TILT_GAIN = 3'd1,
    CFG_TILT_LIM  = 3'd2,
    CFG_KP        = 3'd3,
    CFG_KD        = 3'd4,
    CFG_STALL     = 3'd5,
    CFG_NLS       = 3'd6
  } cfg_idx_e;

  localparam int unsigned CFG_RESET [NUM_CFG] = '{410, 2048, 2048, 4096, 410, 2048, 122880};

endpackage
`default_nettype wire

// ----- hdl/cptc_cfg_regs.sv -----
// configuration register file with write channel and validity check
`default_nettype none
module cptc_cfg_regs #(
  parameter int unsigned CW = 23
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [2:0]    cfg_addr_i,
  input  wire logic [CW-1:0] cfg_data_i,
  output logic [CW-1:0]      cfg_o [cptc_pkg::NUM_CFG],
  output logic               ok_o
);
  import cptc_pkg::*;

  logic [CW-1:0] cfg_q [NUM_CFG];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) cfg_q[i] <= CW'(CFG_RESET[i]);
    end else if (cfg_valid_i && (32'(cfg_addr_i) < NUM_CFG)) begin
      cfg_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  assign cfg_o = cfg_q;

  // derivative gain may be zero, everything else must be set
  assign ok_o = (cfg_q[CFG_RADIUS] != '0) && (cfg_q[CFG_TILT_GAIN] != '0) &&
                (cfg_q[CFG_TILT_LIM] != '0) && (cfg_q[CFG_KP] != '0) &&
                (cfg_q[CFG_STALL] != '0) && (cfg_q[CFG_NLS] != '0);

endmodule
`default_nettype wire

// ----- hdl/cptc_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage, payload rides along
`default_nettype none
module cptc_div_pipe #(
  parameter int unsigned DW = 23,
  parameter int unsigned QW = 12,
  parameter int unsigned PW = 144
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [DW-1:0] div_i,
  input  wire logic          big_i,
  input  wire logic [PW-1:0] pay_i,
  output logic               vld_o,
  output logic [QW-1:0]      quo_o,
  output logic               big_o,
  output logic [PW-1:0]      pay_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] quo_d [QW];
  logic [PW-1:0] pay_q [QW];
  logic [QW-1:0] vld_q;
  logic [QW-1:0] big_q;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] src_rem;
    logic [QW-1:0] src_quo;
    logic [DW:0]   dbl;
    logic [DW:0]   trial;
    logic          ge;
    assign src_rem = (k == 0) ? rem_i : rem_q[(k == 0) ? 0 : k-1];
    assign src_quo = (k == 0) ? '0 : quo_q[(k == 0) ? 0 : k-1];
    assign dbl     = {src_rem, 1'b0};
    assign ge      = dbl >= {1'b0, div_i};
    assign trial   = dbl - {1'b0, div_i};
    assign rem_d[k] = ge ? trial[DW-1:0] : dbl[DW-1:0];
    assign quo_d[k] = {src_quo[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      big_q <= {big_q[QW-2:0], big_i};
      pay_q[0] <= pay_i;
      for (int k = 1; k < QW; k++) pay_q[k] <= pay_q[k-1];
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = quo_q[QW-1];
  assign big_o = big_q[QW-1];
  assign pay_o = pay_q[QW-1];

endmodule
`default_nettype wire

// ----- hdl/cascaded_pendulum_torque_control_top.sv -----
// cascaded speed / pendulum PD controller with motor torque limit, top level
//
// One sample enters on the s_axis channel, one result leaves on m_axis.
// Configuration registers are written on the cfg channel (index, data),
// which is always ready; write only while no sample is in flight.
// The pipeline is five stages of multiply / add / clamp, then FRAC_BITS
// stages of the speed-fraction divider, one stage for the available-torque
// multiply, then FRAC_BITS stages of the normalizing divider, then the
// output register.
// Throughput is one sample per cycle unless the output stalls; the two
// one-bit-per-stage dividers set the depth of the pipeline.
// All stages advance together; when the output register holds a result
// that is not taken, the whole pipe holds and s_axis_tready drops.
// Reset clears all valid bits and loads the registers with their
// default values. With any required register at zero the result is all
// zeros, valid_res included.
`default_nettype none
module cascaded_pendulum_torque_control_top #(
  parameter int unsigned DATA_WIDTH = 24,
  parameter int unsigned FRAC_BITS  = 12
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // shell_roll, shell_rate, pend_rel_angle, pend_rel_rate, target_speed
  input  wire logic [((5*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // est_speed, speed_err, desired_tilt, abs_angle, abs_rate, torque_avail,
  // torque_cmd, cmd_norm, saturated, valid_res
  output logic [((7*DATA_WIDTH+FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic [2:0] cfg_addr_i,
  input  wire logic [DATA_WIDTH-2:0] cfg_data_i
);
  import cptc_pkg::*;

  localparam int unsigned W     = DATA_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned CW    = W - 1;
  localparam int unsigned XW    = 2 * W + 2;
  localparam int unsigned OUT_B = 7 * W + F + 3;
  localparam int unsigned OUT_W = ((OUT_B + 7) / 8) * 8;
  localparam int unsigned PW1   = 6 * W;
  localparam int unsigned PW2   = 7 * W;
  localparam logic signed [XW-1:0] SMAX_X = XW'((longint'(1) <<< (W - 1)) - 1);
  localparam logic signed [XW-1:0] SMIN_X = -SMAX_X - XW'(1);
  localparam logic [F:0] ONE_Q = {1'b1, {F{1'b0}}};

  function automatic logic signed [W-1:0] sat_f(input logic signed [XW-1:0] v);
    if (v > SMAX_X) return {1'b0, {(W-1){1'b1}}};
    else if (v < SMIN_X) return {1'b1, {(W-1){1'b0}}};
    else return v[W-1:0];
  endfunction

  logic [CW-1:0] cfg [NUM_CFG];
  logic          cfg_ok;
  logic          en;

  cptc_cfg_regs #(.CW(CW)) u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i,
    .cfg_o(cfg), .ok_o(cfg_ok)
  );

  logic out_vld_q;
  logic [OUT_W-1:0] out_data_q, out_data_d;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // input fields
  logic signed [W-1:0] roll, rate, rel_a, rel_r, tgt;
  assign roll  = s_axis_tdata[W-1:0];
  assign rate  = s_axis_tdata[2*W-1:W];
  assign rel_a = s_axis_tdata[3*W-1:2*W];
  assign rel_r = s_axis_tdata[4*W-1:3*W];
  assign tgt   = s_axis_tdata[5*W-1:4*W];

  // stage 1: speed estimate, absolute angle and rate, speed magnitude
  logic signed [XW-1:0] est_p;
  logic [W-1:0] mag_in;
  assign est_p  = $signed({1'b0, cfg[CFG_RADIUS]}) * rate;
  assign mag_in = rel_r[W-1] ? W'(-rel_r) : W'(rel_r);

  logic [5:1] v_q;
  logic signed [W-1:0] est1_q, absa1_q, absr1_q, tgt1_q;
  logic [W-1:0] mag1_q;
  // stage 2
  logic signed [W-1:0] err2_q, est2_q, absa2_q, absr2_q;
  logic [W-1:0] mag2_q;
  // stage 3
  logic signed [W-1:0] tilt3_q, err3_q, est3_q, absa3_q, absr3_q;
  logic [W-1:0] mag3_q;
  // stage 4
  logic signed [W-1:0] d4_q, kdp4_q, tilt4_q, err4_q, est4_q, absa4_q, absr4_q;
  logic [W-1:0] mag4_q;
  // stage 5
  logic signed [W-1:0] kpp5_q, kdp5_q, tilt5_q, err5_q, est5_q, absa5_q, absr5_q;
  logic [W-1:0] mag5_q;

  logic signed [XW-1:0] tilt_p, kd_p, kp_p;
  logic signed [W-1:0]  tilt_s, tlim_s, tilt_c;
  assign tilt_p = -($signed({1'b0, cfg[CFG_TILT_GAIN]}) * err2_q);
  assign tilt_s = sat_f(tilt_p >>> F);
  assign tlim_s = $signed({1'b0, cfg[CFG_TILT_LIM]});
  always_comb begin
    priority if (tilt_s > tlim_s) tilt_c = tlim_s;
    else if (tilt_s < -tlim_s)    tilt_c = -tlim_s;
    else                          tilt_c = tilt_s;
  end
  assign kd_p = $signed({1'b0, cfg[CFG_KD]}) * absr3_q;
  assign kp_p = $signed({1'b0, cfg[CFG_KP]}) * d4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      est1_q  <= sat_f(est_p >>> F);
      absa1_q <= sat_f(XW'(roll) + XW'(rel_a));
      absr1_q <= sat_f(XW'(rate) + XW'(rel_r));
      tgt1_q  <= tgt;
      mag1_q  <= mag_in;

      err2_q  <= sat_f(XW'(tgt1_q) - XW'(est1_q));
      est2_q  <= est1_q;
      absa2_q <= absa1_q;
      absr2_q <= absr1_q;
      mag2_q  <= mag1_q;

      tilt3_q <= tilt_c;
      err3_q  <= err2_q;
      est3_q  <= est2_q;
      absa3_q <= absa2_q;
      absr3_q <= absr2_q;
      mag3_q  <= mag2_q;

      d4_q    <= sat_f(XW'(tilt3_q) - XW'(absa3_q));
      kdp4_q  <= sat_f(kd_p >>> F);
      tilt4_q <= tilt3_q;
      err4_q  <= err3_q;
      est4_q  <= est3_q;
      absa4_q <= absa3_q;
      absr4_q <= absr3_q;
      mag4_q  <= mag3_q;

      kpp5_q  <= sat_f(kp_p >>> F);
      kdp5_q  <= kdp4_q;
      tilt5_q <= tilt4_q;
      err5_q  <= err4_q;
      est5_q  <= est4_q;
      absa5_q <= absa4_q;
      absr5_q <= absr4_q;
      mag5_q  <= mag4_q;
    end
  end

  // speed fraction divider; a magnitude at or above no-load speed caps at one
  logic signed [W-1:0] raw5;
  logic big1_in;
  assign raw5    = sat_f(XW'(kpp5_q) - XW'(kdp5_q));
  assign big1_in = mag5_q >= {1'b0, cfg[CFG_NLS]};

  logic          d1_vld, d1_big;
  logic [F-1:0]  d1_quo;
  logic [PW1-1:0] d1_pay;

  cptc_div_pipe #(.DW(CW), .QW(F), .PW(PW1)) u_div_frac (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v_q[5]),
    .rem_i(mag5_q[CW-1:0]), .div_i(cfg[CFG_NLS]), .big_i(big1_in),
    .pay_i({raw5, absr5_q, absa5_q, tilt5_q, err5_q, est5_q}),
    .vld_o(d1_vld), .quo_o(d1_quo), .big_o(d1_big), .pay_o(d1_pay)
  );

  // available torque on the linear torque-speed curve
  logic [F:0]      frac, one_minus;
  logic [CW+F:0]   avail_p;
  assign frac      = d1_big ? ONE_Q : {1'b0, d1_quo};
  assign one_minus = ONE_Q - frac;
  assign avail_p   = cfg[CFG_STALL] * one_minus;

  logic           v7_q;
  logic [CW-1:0]  avail7_q;
  logic [PW1-1:0] pay7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      avail7_q <= avail_p[CW+F-1:F];
      pay7_q   <= d1_pay;
    end
  end

  // torque clamp and normalizer input
  logic signed [W-1:0] raw7, avail_s, torque, torque_abs;
  logic [W-1:0]        raw_abs;
  logic                sat_flag;
  assign raw7    = pay7_q[6*W-1:5*W];
  assign avail_s = $signed({1'b0, avail7_q});
  assign raw_abs = raw7[W-1] ? W'(-raw7) : W'(raw7);
  assign sat_flag = raw_abs > {1'b0, avail7_q};
  always_comb begin
    priority if (raw7 > avail_s) torque = avail_s;
    else if (raw7 < -avail_s)    torque = -avail_s;
    else                         torque = raw7;
  end
  assign torque_abs = torque[W-1] ? -torque : torque;

  logic           d2_vld, d2_big;
  logic [F-1:0]   d2_quo;
  logic [PW2-1:0] d2_pay;

  cptc_div_pipe #(.DW(CW), .QW(F), .PW(PW2)) u_div_norm (
    .clk_i, .rst_ni, .en_i(en), .vld_i(v7_q),
    .rem_i(torque_abs[CW-1:0]), .div_i(cfg[CFG_STALL]),
    .big_i(torque_abs[CW-1:0] == cfg[CFG_STALL]),
    .pay_i({sat_flag, torque, avail7_q, pay7_q[5*W-1:0]}),
    .vld_o(d2_vld), .quo_o(d2_quo), .big_o(d2_big), .pay_o(d2_pay)
  );

  // sign the normalized command and pack the result
  logic [F:0]          norm_mag;
  logic signed [F+1:0] norm;
  assign norm_mag = d2_big ? ONE_Q : {1'b0, d2_quo};
  assign norm     = d2_pay[7*W-2] ? -$signed({1'b0, norm_mag}) : $signed({1'b0, norm_mag});

  always_comb begin
    out_data_d = '0;
    if (cfg_ok) begin
      out_data_d = OUT_W'({1'b1, d2_pay[7*W-1], norm, d2_pay[7*W-2:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

// ----- hdl/cptc_checker.sv -----
// port-level checks for the pendulum torque controller, bound to the top level
`default_nettype none
module cptc_checker #(
  parameter int unsigned DATA_WIDTH = 24,
  parameter int unsigned FRAC_BITS  = 12
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [((7*DATA_WIDTH+FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned W   = DATA_WIDTH;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned AV  = 5 * W;
  localparam int unsigned TQ  = 6 * W - 1;
  localparam int unsigned SB  = 7 * W + F + 1;
  localparam int unsigned VB  = 7 * W + F + 2;

  logic signed [W-1:0] torque_f, avail_f;
  assign torque_f = m_axis_tdata[TQ+W-1:TQ];
  assign avail_f  = $signed({1'b0, m_axis_tdata[AV+W-2:AV]});

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the input side only waits on a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // an invalid result carries nothing
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[VB] |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero fields");

  // a saturated command sits on the available torque
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[SB] |-> torque_f == avail_f || torque_f == -avail_f)
    else $error("saturated command off the torque limit");

endmodule

bind cascaded_pendulum_torque_control_top cptc_checker #(
  .DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)
) u_cptc_checker (.*);
`default_nettype wire

// ----- sim/testbench.sv -----
// self-checking stream testbench for the cascaded pendulum torque controller
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cptc_pkg::*;

  localparam int DW = 24;
  localparam int FB = 12;
  localparam longint SMAX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint SMIN = -(64'sd1 <<< (DW - 1));
  localparam longint ONE_Q = 64'sd1 <<< FB;
  localparam logic [2:0] CFG_NONE = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * FB + 16;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_NOMINAL_ZERO, ROW_ALL_ZERO} row_kind_e;
  typedef struct packed {
    logic [DW-1:0] tgt, rel_rate, rel_angle, rate, roll;
  } sample_t;
  typedef struct {
    sample_t   s;
    row_kind_e kind;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready;
  logic [119:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [183:0] m_axis_tdata;
  logic cfg_valid_i, cfg_ready_o;
  logic [2:0] cfg_addr_i;
  logic [DW-2:0] cfg_data_i;

  cascaded_pendulum_torque_control_top u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_addr_i, .cfg_data_i
  );

  longint gains [NUM_CFG];
  logic [183:0] expected_results [$];
  int errors = 0;
  int idle_cycles = 0;
  bit fast = 0;

  // result field layout, lowest bit up
  localparam int FLD_OFS [10] = '{0, 24, 48, 72, 96, 120, 143, 167, 181, 182};
  localparam int FLD_W   [10] = '{24, 24, 24, 24, 24, 23, 24, 14, 1, 1};
  localparam string FLD_NAME [10] = '{"est_speed", "speed_err", "desired_tilt",
    "abs_angle", "abs_rate", "torque_avail", "torque_cmd", "cmd_norm",
    "saturated", "valid_res"};

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint sat(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [183:0] control_law(sample_t s);
    longint roll, rate, ra, rr, tgt, est, err, tilt, aa, ar;
    longint mag, frac, avail, raw, torq, norm;
    logic satf;
    roll = longint'($signed(s.roll));
    rate = longint'($signed(s.rate));
    ra   = longint'($signed(s.rel_angle));
    rr   = longint'($signed(s.rel_rate));
    tgt  = longint'($signed(s.tgt));
    if (gains[CFG_RADIUS] == 0 || gains[CFG_TILT_GAIN] == 0 || gains[CFG_TILT_LIM] == 0 ||
        gains[CFG_KP] == 0 || gains[CFG_STALL] == 0 || gains[CFG_NLS] == 0)
      return '0;
    est  = sat((gains[CFG_RADIUS] * rate) >>> FB);
    err  = sat(tgt - est);
    tilt = clampv(sat((-(gains[CFG_TILT_GAIN] * err)) >>> FB),
                  -gains[CFG_TILT_LIM], gains[CFG_TILT_LIM]);
    aa   = sat(roll + ra);
    ar   = sat(rate + rr);
    mag  = rr < 0 ? -rr : rr;
    frac = (mag * ONE_Q) / gains[CFG_NLS];
    if (frac > ONE_Q) frac = ONE_Q;
    avail = (gains[CFG_STALL] * (ONE_Q - frac)) >>> FB;
    raw  = sat(sat((gains[CFG_KP] * sat(tilt - aa)) >>> FB) - sat((gains[CFG_KD] * ar) >>> FB));
    torq = clampv(raw, -avail, avail);
    norm = (torq * ONE_Q) / gains[CFG_STALL];
    satf = ((raw < 0 ? -raw : raw) > avail);
    return {1'b0, 1'b1, satf, norm[13:0], torq[23:0], avail[22:0],
            ar[23:0], aa[23:0], tilt[23:0], err[23:0], est[23:0]};
  endfunction

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 24'h7fffff;
      1: return 24'h800000;
      2: return '0;
      3, 4, 5: return DW'($signed($urandom_range(0, 32768)) - 16384);
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic logic [DW-2:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 23'h7fffff;
      1: return 23'd1;
      2, 3: return 23'($urandom_range(1, 16384));
      default: return 23'($urandom);
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [DW-2:0] val);
    cfg_valid_i = 1;
    cfg_addr_i  = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NUM_CFG) gains[idx] = longint'(val);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  // wait until the pipe is empty before touching registers
  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic send(sample_t s, row_kind_e kind);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      s_axis_tvalid = 0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1;
    s_axis_tdata  = s;
    do @(posedge clk_i); while (!s_axis_tready);
    case (kind)
      ROW_NOMINAL_ZERO: expected_results.push_back({1'b0, 1'b1, 1'b0, 14'd0, 24'd0,
                                                    23'd2048, {5{24'd0}}});
      ROW_ALL_ZERO:     expected_results.push_back('0);
      default:          expected_results.push_back(control_law(s));
    endcase
    @(negedge clk_i);
  endtask

  task automatic random_run(int n);
    sample_t s;
    repeat (n) begin
      if ($urandom_range(0, 39) == 0) fast = ~fast;
      s = {pick_value(), pick_value(), pick_value(), pick_value(), pick_value()};
      send(s, ROW_PREDICT);
    end
    s_axis_tvalid = 0;
    fast = 0;
  endtask

  // receiver side
  initial begin
    int w;
    m_axis_tready = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      w = fast ? 0 : $urandom_range(0, 15);
      m_axis_tready = 0;
      repeat (w) @(negedge clk_i);
      m_axis_tready = 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    logic [183:0] exp_r;
    logic [23:0] e, a;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          exp_r = expected_results.pop_front();
          for (int f = 0; f < 10; f++) begin
            e = 24'((exp_r >> FLD_OFS[f]) & ((184'd1 << FLD_W[f]) - 1));
            a = 24'((m_axis_tdata >> FLD_OFS[f]) & ((184'd1 << FLD_W[f]) - 1));
            if (e !== a) begin
              errors = errors + 1;
              if (errors <= 10)
                $display("mismatch %s: expected %h got %h", FLD_NAME[f], e, a);
            end
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  stim_row_t rows [$];

  initial begin
    sample_t z;
    z = '0;
    s_axis_tvalid = 0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 0;
    cfg_addr_i    = CFG_RADIUS;
    cfg_data_i    = '0;
    for (int i = 0; i < NUM_CFG; i++) gains[i] = longint'(CFG_RESET[i]);
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed rows at reset settings
    rows.push_back('{z, ROW_NOMINAL_ZERO});
    rows.push_back('{{5{24'h7fffff}}, ROW_PREDICT});
    rows.push_back('{{5{24'h800000}}, ROW_PREDICT});
    rows.push_back('{{24'h7fffff, 24'h0, 24'h800000, 24'h7fffff, 24'h800000}, ROW_PREDICT});
    rows.push_back('{{24'h800000, 24'h7fffff, 24'h0, 24'h800000, 24'h7fffff}, ROW_PREDICT});
    // relative speed at, above and below no-load speed
    rows.push_back('{{24'd0, 24'd122880, 24'd0, 24'd0, 24'd0}, ROW_PREDICT});
    rows.push_back('{{24'd0, -24'sd122880, 24'd100, 24'd0, 24'd0}, ROW_PREDICT});
    rows.push_back('{{24'd0, 24'd122879, 24'd0, 24'd0, 24'd0}, ROW_PREDICT});
    rows.push_back('{{24'd0, 24'd200000, 24'd0, 24'd0, 24'd0}, ROW_PREDICT});
    // tilt clamp both ways
    rows.push_back('{{24'd40960, 24'd0, 24'd0, 24'd0, 24'd0}, ROW_PREDICT});
    rows.push_back('{{-24'sd40960, 24'd0, 24'd0, 24'd0, 24'd0}, ROW_PREDICT});
    rows.push_back('{{24'd0, 24'd0, 24'd0, 24'd4096, 24'd0}, ROW_PREDICT});
    rows.push_back('{{24'd0, 24'd0, 24'd0, 24'd0, 24'd4096}, ROW_PREDICT});
    rows.push_back('{{24'd0, 24'd0, -24'sd9000, 24'd0, 24'd0}, ROW_PREDICT});
    foreach (rows[i]) send(rows[i].s, rows[i].kind);
    s_axis_tvalid = 0;
    random_run(150);

    // every gain at its maximum: saturated products and raw torque
    drain();
    for (int i = 0; i < NUM_CFG; i++) write_reg(cfg_idx_e'(i), 23'h7fffff);
    send({5{24'h7fffff}}, ROW_PREDICT);
    send({5{24'h800000}}, ROW_PREDICT);
    send({24'd0, 24'd0, 24'h800000, 24'd0, 24'h800000}, ROW_PREDICT);
    s_axis_tvalid = 0;
    random_run(150);

    // smallest nonzero gains
    drain();
    for (int i = 0; i < NUM_CFG; i++) write_reg(cfg_idx_e'(i), 23'd1);
    random_run(120);

    // zero derivative gain is still a valid setting
    drain();
    for (int i = 0; i < NUM_CFG; i++) write_reg(cfg_idx_e'(i), pick_gain());
    write_reg(CFG_KD, '0);
    random_run(120);

    // a required register at zero gives all-zero results
    drain();
    write_reg(CFG_RADIUS, '0);
    send(z, ROW_ALL_ZERO);
    send({5{24'h7fffff}}, ROW_ALL_ZERO);
    s_axis_tvalid = 0;
    random_run(40);
    drain();
    write_reg(CFG_RADIUS, 23'd410);
    write_reg(CFG_STALL, '0);
    random_run(40);
    drain();
    write_reg(CFG_STALL, 23'd2048);
    write_reg(CFG_NLS, '0);
    random_run(40);

    // out of range index is ignored
    drain();
    write_reg(CFG_NLS, 23'd122880);
    write_reg(CFG_NONE, 23'($urandom));
    random_run(60);

    for (int p = 0; p < 4; p++) begin
      drain();
      for (int i = 0; i < NUM_CFG; i++) write_reg(cfg_idx_e'(i), pick_gain());
      random_run(120);
    end

    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/cptc_pkg.sv
hdl/cptc_cfg_regs.sv
hdl/cptc_div_pipe.sv
hdl/cascaded_pendulum_torque_control_top.sv
hdl/cptc_checker.sv
sim/testbench.sv
